[hdl/ctk_pkg.sv]
// Shared types, constants and character classes for the source tokenizer.
package ctk_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int FIELD_BITS  = 20;
  localparam int MAX_RES     = 3;
  localparam int CNT_BITS    = $clog2(MAX_RES + 1);

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [FIELD_BITS-1:0]  field_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  localparam pos_t POS_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_P   = 8'h50;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_P   = 8'h70;

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_QUOTED  = 3'd2,
    KIND_PUNCT   = 3'd3,
    KIND_END     = 3'd4,
    KIND_INVALID = 3'd5
  } tok_kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_SLASH  = 4'd1,
    MODE_DOT    = 4'd2,
    MODE_LINE   = 4'd3,
    MODE_BLOCK  = 4'd4,
    MODE_IDENT  = 4'd5,
    MODE_NUMBER = 4'd6,
    MODE_QUOTED = 4'd7,
    MODE_ESCAPE = 4'd8
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t  mode;
    pos_t        pos;
    pos_t        tok_begin;
    logic [7:0]  prev;
    logic        quote_double;
    logic        halted;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:         MODE_IDLE,
    pos:          '0,
    tok_begin:    '0,
    prev:         '0,
    quote_double: 1'b0,
    halted:       1'b0
  };

  typedef struct packed {
    tok_kind_t kind;
    pos_t      tok_begin;
    pos_t      tok_end;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RES-1:0] toks;
    cnt_t               cnt;
  } res_list_t;

  function automatic logic is_white(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic id_start(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic id_cont(logic [7:0] c);
    return id_start(c) || is_digit(c);
  endfunction

  function automatic field_t to_field(pos_t v);
    logic [OFFSET_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

[hdl/ctk_in_if.sv]
// Source byte channel: valid/ready handshake with one byte item.
interface ctk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       stream_end;

  modport source (output valid, output data_byte, output byte_present, output stream_end,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input stream_end,
                output ready);
endinterface

[hdl/ctk_out_if.sv]
// Token channel: valid/ready handshake with one token item.
interface ctk_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   token_kind;
  logic [ctk_pkg::FIELD_BITS-1:0] token_begin;
  logic [ctk_pkg::FIELD_BITS-1:0] token_end;
  logic                         last_of_run;

  modport source (output valid, output token_kind, output token_begin, output token_end,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_begin, input token_end,
                input last_of_run, output ready);
endinterface

[hdl/ctk_step.sv]
// Scanner next-state logic: one source item in, updated state and up to three tokens out.
module ctk_step (
  input  ctk_pkg::state_t    cur_state,
  input  logic [7:0]         data_byte,
  input  logic               byte_present,
  input  logic               stream_end,
  output ctk_pkg::state_t    nxt_state,
  output ctk_pkg::res_list_t res
);

  function automatic ctk_pkg::res_list_t push(ctk_pkg::res_list_t l, ctk_pkg::tok_kind_t k,
                                              ctk_pkg::pos_t b, ctk_pkg::pos_t e);
    ctk_pkg::res_list_t r;
    r = l;
    if (r.cnt < ctk_pkg::CNT_BITS'(ctk_pkg::MAX_RES)) begin
      r.toks[r.cnt] = '{kind: k, tok_begin: b, tok_end: e};
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    ctk_pkg::state_t    st;
    ctk_pkg::res_list_t rl;
    logic [7:0]         c;
    ctk_pkg::pos_t      p;
    logic               do_idle;
    logic               skip_prev;
    logic               exp_ok;
    logic [7:0]         close_ch;

    st        = cur_state;
    rl        = '0;
    c         = data_byte;
    p         = cur_state.pos;
    do_idle   = 1'b0;
    skip_prev = 1'b0;
    exp_ok    = (cur_state.prev == ctk_pkg::CH_LO_E) || (cur_state.prev == ctk_pkg::CH_UP_E) ||
                (cur_state.prev == ctk_pkg::CH_LO_P) || (cur_state.prev == ctk_pkg::CH_UP_P);
    close_ch  = cur_state.quote_double ? ctk_pkg::CH_DQUOTE : ctk_pkg::CH_SQUOTE;

    if (byte_present && !st.halted) begin
      if (st.pos == ctk_pkg::POS_MAX) begin
        rl = push(rl, ctk_pkg::KIND_INVALID, p, p);
        st.halted = 1'b1;
        st.mode = ctk_pkg::MODE_IDLE;
      end else begin
        unique case (st.mode)
          ctk_pkg::MODE_SLASH: begin
            if (c == ctk_pkg::CH_SLASH) begin
              st.mode = ctk_pkg::MODE_LINE;
            end else if (c == ctk_pkg::CH_STAR) begin
              st.mode = ctk_pkg::MODE_BLOCK;
              skip_prev = 1'b1;
            end else begin
              rl = push(rl, ctk_pkg::KIND_PUNCT, st.tok_begin,
                        ctk_pkg::pos_t'(st.tok_begin + 1'b1));
              do_idle = 1'b1;
            end
          end
          ctk_pkg::MODE_DOT: begin
            if (ctk_pkg::is_digit(c)) begin
              st.mode = ctk_pkg::MODE_NUMBER;
            end else begin
              rl = push(rl, ctk_pkg::KIND_PUNCT, st.tok_begin,
                        ctk_pkg::pos_t'(st.tok_begin + 1'b1));
              do_idle = 1'b1;
            end
          end
          ctk_pkg::MODE_LINE: begin
            if (c == ctk_pkg::CH_NL) begin
              st.mode = ctk_pkg::MODE_IDLE;
            end else if (c == ctk_pkg::CH_NUL) begin
              rl = push(rl, ctk_pkg::KIND_INVALID, st.tok_begin, p);
              st.halted = 1'b1;
              st.mode = ctk_pkg::MODE_IDLE;
            end
          end
          ctk_pkg::MODE_BLOCK: begin
            if (c == ctk_pkg::CH_NUL) begin
              rl = push(rl, ctk_pkg::KIND_INVALID, st.tok_begin, p);
              st.halted = 1'b1;
              st.mode = ctk_pkg::MODE_IDLE;
            end else if (st.prev == ctk_pkg::CH_STAR && c == ctk_pkg::CH_SLASH) begin
              st.mode = ctk_pkg::MODE_IDLE;
            end
          end
          ctk_pkg::MODE_IDENT: begin
            if (!ctk_pkg::id_cont(c)) begin
              rl = push(rl, ctk_pkg::KIND_IDENT, st.tok_begin, p);
              do_idle = 1'b1;
            end
          end
          ctk_pkg::MODE_NUMBER: begin
            if (!(ctk_pkg::id_cont(c) || c == ctk_pkg::CH_DOT ||
                  ((c == ctk_pkg::CH_PLUS || c == ctk_pkg::CH_MINUS) && exp_ok))) begin
              rl = push(rl, ctk_pkg::KIND_NUMBER, st.tok_begin, p);
              do_idle = 1'b1;
            end
          end
          ctk_pkg::MODE_QUOTED: begin
            if (c == ctk_pkg::CH_NUL) begin
              rl = push(rl, ctk_pkg::KIND_INVALID, st.tok_begin, p);
              st.halted = 1'b1;
              st.mode = ctk_pkg::MODE_IDLE;
            end else if (c == close_ch) begin
              rl = push(rl, ctk_pkg::KIND_QUOTED, st.tok_begin, ctk_pkg::pos_t'(p + 1'b1));
              st.mode = ctk_pkg::MODE_IDLE;
            end else if (c == ctk_pkg::CH_BSLASH) begin
              st.mode = ctk_pkg::MODE_ESCAPE;
            end
          end
          ctk_pkg::MODE_ESCAPE: begin
            if (c == ctk_pkg::CH_NUL) begin
              rl = push(rl, ctk_pkg::KIND_INVALID, st.tok_begin, p);
              st.halted = 1'b1;
              st.mode = ctk_pkg::MODE_IDLE;
            end else begin
              st.mode = ctk_pkg::MODE_QUOTED;
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        if (do_idle) begin
          st.mode = ctk_pkg::MODE_IDLE;
          if (!ctk_pkg::is_white(c)) begin
            st.tok_begin = p;
            if (c == ctk_pkg::CH_SLASH) begin
              st.mode = ctk_pkg::MODE_SLASH;
            end else if (c == ctk_pkg::CH_DOT) begin
              st.mode = ctk_pkg::MODE_DOT;
            end else if (c == ctk_pkg::CH_NUL || c == ctk_pkg::CH_BSLASH) begin
              rl = push(rl, ctk_pkg::KIND_INVALID, p, p);
              st.halted = 1'b1;
            end else if (ctk_pkg::id_start(c)) begin
              st.mode = ctk_pkg::MODE_IDENT;
            end else if (ctk_pkg::is_digit(c)) begin
              st.mode = ctk_pkg::MODE_NUMBER;
            end else if (c == ctk_pkg::CH_DQUOTE || c == ctk_pkg::CH_SQUOTE) begin
              st.mode = ctk_pkg::MODE_QUOTED;
              st.quote_double = (c == ctk_pkg::CH_DQUOTE);
            end else begin
              rl = push(rl, ctk_pkg::KIND_PUNCT, p, ctk_pkg::pos_t'(p + 1'b1));
            end
          end
        end

        st.prev = skip_prev ? 8'h00 : c;
        st.pos  = ctk_pkg::pos_t'(st.pos + 1'b1);
      end
    end

    if (stream_end) begin
      if (!st.halted) begin
        unique case (st.mode)
          ctk_pkg::MODE_SLASH, ctk_pkg::MODE_DOT: begin
            rl = push(rl, ctk_pkg::KIND_PUNCT, st.tok_begin,
                      ctk_pkg::pos_t'(st.tok_begin + 1'b1));
          end
          ctk_pkg::MODE_IDENT: begin
            rl = push(rl, ctk_pkg::KIND_IDENT, st.tok_begin, st.pos);
          end
          ctk_pkg::MODE_NUMBER: begin
            rl = push(rl, ctk_pkg::KIND_NUMBER, st.tok_begin, st.pos);
          end
          ctk_pkg::MODE_BLOCK, ctk_pkg::MODE_QUOTED, ctk_pkg::MODE_ESCAPE: begin
            rl = push(rl, ctk_pkg::KIND_INVALID, st.tok_begin, st.pos);
            st.halted = 1'b1;
          end
          default: begin
          end
        endcase
        if (!st.halted) begin
          rl = push(rl, ctk_pkg::KIND_END, st.pos, st.pos);
        end
      end
      st = ctk_pkg::STATE_RESET;
    end

    nxt_state = st;
    res       = rl;
  end

endmodule

[hdl/c_like_source_tokenizer_top.sv]
// C-style source tokenizer: top level with scanner state and token output buffer.
//
// The block scans one source byte per cycle when not stalled, and emits identifier, number,
// quoted, punctuation, end and invalid tokens with begin and end offsets. An item that yields
// at most one token is taken every cycle while out_chan is ready; one that yields two or three
// tokens (a pending token closed by a new one, or a stream-end flush) holds in_chan.ready low
// until out_chan takes the last of them from the three-entry buffer, one per transfer. A '/'
// or '.' token appears only after the next byte or the stream end. After an invalid token the
// block drops bytes until an item with stream_end set, and every stream restarts at offset 0.
module c_like_source_tokenizer_top (
  input logic         clk,
  input logic         rst_n,
  ctk_in_if.sink      in_chan,
  ctk_out_if.source   out_chan
);

  ctk_pkg::state_t                   state_r;
  ctk_pkg::state_t                   state_nxt;
  ctk_pkg::res_list_t                step_res;
  ctk_pkg::tok_t [ctk_pkg::MAX_RES-1:0] tok_r;
  ctk_pkg::cnt_t                     cnt_r;
  logic [$clog2(ctk_pkg::MAX_RES)-1:0] rd_r;
  ctk_pkg::tok_t                     head_tok;
  logic                              in_xfer;
  logic                              out_xfer;

  ctk_step u_step (
    .cur_state    (state_r),
    .data_byte    (in_chan.data_byte),
    .byte_present (in_chan.byte_present),
    .stream_end   (in_chan.stream_end),
    .nxt_state    (state_nxt),
    .res          (step_res)
  );

  assign in_chan.ready = (cnt_r == '0) || ((cnt_r == ctk_pkg::cnt_t'(1)) && out_chan.ready);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_xfer      = out_chan.valid && out_chan.ready;

  assign head_tok             = tok_r[rd_r];
  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.token_kind  = head_tok.kind;
  assign out_chan.token_begin = ctk_pkg::to_field(head_tok.tok_begin);
  assign out_chan.token_end   = ctk_pkg::to_field(head_tok.tok_end);
  assign out_chan.last_of_run = (cnt_r == ctk_pkg::cnt_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctk_pkg::STATE_RESET;
      cnt_r   <= '0;
      rd_r    <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
      cnt_r   <= step_res.cnt;
      rd_r    <= '0;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - 1'b1;
      rd_r  <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tok_r <= step_res.toks;
    end
  end

endmodule
